// File: hdl/tlms_pkg.sv
package tlms_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LEVEL        = 3'd0,
    CFG_MIX_COEF     = 3'd1,
    CFG_RESULT_SHIFT = 3'd2,
    CFG_FIRST_COL    = 3'd3,
    CFG_LAST_COL     = 3'd4,
    CFG_FIRST_ROW    = 3'd5,
    CFG_LAST_ROW     = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PosW     = 7;
  localparam int unsigned DataW    = 32;
  localparam int unsigned DepthW   = 8;
  localparam int unsigned ShiftW   = 6;

  // Widths of the exact intermediate results.
  localparam int unsigned TermW = 65;
  localparam int unsigned SumW  = 67;
  localparam int unsigned ProdW = 100;

endpackage

// File: hdl/tracer_laplacian_mix_stencil.sv
// Five-point Laplacian mixing stencil. Grid points enter in raster order, ROW_LENGTH
// points per row and ROW_COUNT rows per frame, and the counters wrap to row 0 after the
// last point of a frame. Point (r,c) leaves when point (r+1,c) enters, and only when it
// is inside both the configured bounds and the one-point halo. Two rows of tracer values
// and one row of masked coefficients sit in synchronous memories, each with one read
// port and one write port. A point that gives no result passes through the accepting
// cycle and the write-back. A point that gives a result passes through the accepting
// cycle, 4 memory reads, the write-back, 5 steps through the shared 33x33 term
// multiplier and 3 steps through the 33x33 multiplier that forms the scaled 100-bit
// product, and a final state that shifts and saturates. That final state holds while
// the output register still holds a stalled result. The output register lets the next
// point enter while a result waits. Configuration writes are always ready.
module tracer_laplacian_mix_stencil #(
  parameter int unsigned ROW_LENGTH = 128,
  parameter int unsigned ROW_COUNT  = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tlms_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tlms_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tlms_pkg::DataW-1:0]   tracer_i,
  input  logic [tlms_pkg::DataW-1:0]          coef_prev_row_i,
  input  logic [tlms_pkg::DataW-1:0]          coef_next_row_i,
  input  logic [tlms_pkg::DataW-1:0]          coef_next_col_i,
  input  logic [tlms_pkg::DataW-1:0]          coef_prev_col_i,
  input  logic [tlms_pkg::DepthW-1:0]         depth_here_i,
  input  logic [tlms_pkg::DepthW-1:0]         depth_prev_row_i,
  input  logic [tlms_pkg::DepthW-1:0]         depth_next_row_i,
  input  logic [tlms_pkg::DepthW-1:0]         depth_next_col_i,
  input  logic [tlms_pkg::DepthW-1:0]         depth_prev_col_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tlms_pkg::PosW-1:0]           out_row_o,
  output logic [tlms_pkg::PosW-1:0]           out_col_o,
  output logic signed [tlms_pkg::DataW-1:0]   tendency_o,
  output logic                                saturated_o
);
  import tlms_pkg::*;

  localparam int unsigned CW = $clog2(ROW_LENGTH);
  localparam int unsigned RW = $clog2(ROW_COUNT);
  localparam int unsigned AW = $clog2(2 * ROW_LENGTH);
  localparam logic [AW-1:0] RowOff = AW'(ROW_LENGTH);
  localparam logic [CW-1:0] LastCol = CW'(ROW_LENGTH - 1);
  localparam logic [RW-1:0] LastRow = RW'(ROW_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_C, ST_RD_E, ST_RD_W, ST_RD_N, ST_WB, ST_TERM, ST_MIX, ST_FIN
  } state_e;

  // Configuration registers.
  logic [DepthW-1:0] level_q;
  logic [DataW-1:0]  mix_coef_q;
  logic [ShiftW-1:0] result_shift_q;
  logic [PosW-1:0]   first_col_q, last_col_q, first_row_q, last_row_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q        <= '0;
      mix_coef_q     <= '0;
      result_shift_q <= ShiftW'(32);
      first_col_q    <= PosW'(1);
      last_col_q     <= PosW'(126);
      first_row_q    <= PosW'(1);
      last_row_q     <= PosW'(126);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEVEL:        level_q        <= cfg_data_i[DepthW-1:0];
        CFG_MIX_COEF:     mix_coef_q     <= cfg_data_i;
        CFG_RESULT_SHIFT: result_shift_q <= cfg_data_i[ShiftW-1:0];
        CFG_FIRST_COL:    first_col_q    <= cfg_data_i[PosW-1:0];
        CFG_LAST_COL:     last_col_q     <= cfg_data_i[PosW-1:0];
        CFG_FIRST_ROW:    first_row_q    <= cfg_data_i[PosW-1:0];
        CFG_LAST_ROW:     last_row_q     <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  state_e           state_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic             emit_q;
  logic [2:0]       step_q;
  logic             out_valid_q;

  // Latched word and working registers.
  logic signed [DataW-1:0] ts_q, tc_q, te_q, tw_q, tn_q;
  logic [4*DataW-1:0]      mc_q, k_q;
  logic [PosW-1:0]         emit_row_q, emit_col_q;
  logic signed [TermW-1:0] prod_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [ProdW-1:0] acc_q;
  logic [PosW-1:0]         out_row_q, out_col_q;
  logic signed [DataW-1:0] tendency_q;
  logic                    saturated_q;

  // Memories.
  logic [DataW-1:0]   trc_mem [2*ROW_LENGTH];
  logic [4*DataW-1:0] coef_mem [ROW_LENGTH];
  logic [DataW-1:0]   trc_rdata_q;
  logic [4*DataW-1:0] coef_rdata_q;
  logic [AW-1:0]      trc_raddr;
  logic               trc_we, coef_we;

  assign in_stall_o = (state_q != ST_IDLE);
  wire in_acc = in_valid_i && !in_stall_o;

  // Coefficient masking of the incoming word.
  logic [DepthW:0] kk;
  logic [4*DataW-1:0] mc_d;
  logic [DepthW:0] dh;
  always_comb begin
    kk = {1'b0, level_q} + (DepthW+1)'(1);
    dh = {1'b0, depth_here_i};
    mc_d[0*DataW +: DataW] = (kk <= {1'b0, depth_prev_row_i} && kk <= dh)
                             ? coef_prev_row_i : '0;
    mc_d[1*DataW +: DataW] = (kk <= {1'b0, depth_next_row_i} && kk <= dh)
                             ? coef_next_row_i : '0;
    mc_d[2*DataW +: DataW] = (kk <= {1'b0, depth_next_col_i} && kk <= dh)
                             ? coef_next_col_i : '0;
    mc_d[3*DataW +: DataW] = (kk <= {1'b0, depth_prev_col_i} && kk <= dh)
                             ? coef_prev_col_i : '0;
  end

  // Interior test for the point one row up.
  logic [8:0] r_ext, c_ext;
  logic       interior;
  always_comb begin
    r_ext    = 9'(row_q) - 9'd1;
    c_ext    = 9'(col_q);
    interior = (row_q >= RW'(2)) && (col_q != '0) && (col_q != LastCol) &&
               (r_ext >= 9'(first_row_q)) && (r_ext <= 9'(last_row_q)) &&
               (c_ext >= 9'(first_col_q)) && (c_ext <= 9'(last_col_q));
  end

  // Memory addresses: slot of the previous row and of the current row.
  logic [AW-1:0] prev_base, cur_base, col_a;
  always_comb begin
    col_a     = AW'(col_q);
    prev_base = row_q[0] ? '0 : RowOff;
    cur_base  = row_q[0] ? RowOff : '0;
    unique case (state_q)
      ST_RD_E: trc_raddr = prev_base + col_a + AW'(1);
      ST_RD_W: trc_raddr = prev_base + col_a - AW'(1);
      ST_RD_N: trc_raddr = cur_base + col_a;
      default: trc_raddr = prev_base + col_a;
    endcase
    trc_we  = (state_q == ST_WB);
    coef_we = (state_q == ST_WB);
  end

  always_ff @(posedge clk_i) begin
    trc_rdata_q  <= trc_mem[trc_raddr];
    coef_rdata_q <= coef_mem[col_q];
    if (trc_we) begin
      trc_mem[cur_base + col_a] <= ts_q;
    end
    if (coef_we) begin
      coef_mem[col_q] <= mc_q;
    end
  end

  // Term multiplier: coefficient times neighbor minus centre.
  logic signed [DataW:0]     nb_sel, diff;
  logic [DataW-1:0]          k_sel;
  logic signed [TermW:0]     term_full;
  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin nb_sel = 33'(tn_q); k_sel = k_q[0*DataW +: DataW]; end
      2'd1: begin nb_sel = 33'(ts_q); k_sel = k_q[1*DataW +: DataW]; end
      2'd2: begin nb_sel = 33'(te_q); k_sel = k_q[2*DataW +: DataW]; end
      default: begin nb_sel = 33'(tw_q); k_sel = k_q[3*DataW +: DataW]; end
    endcase
    diff      = nb_sel - 33'(tc_q);
    term_full = $signed({1'b0, k_sel}) * diff;
  end

  // Scale multiplier: one slice of the sum (32 bits, or the top 3 bits) times mix_coef.
  logic signed [DataW:0]     slice;
  logic signed [2*DataW+1:0] part;
  logic signed [ProdW-1:0]   part_sh;
  always_comb begin
    unique case (step_q[1:0])
      2'd0: slice = $signed({1'b0, sum_q[31:0]});
      2'd1: slice = $signed({1'b0, sum_q[63:32]});
      default: slice = 33'($signed(sum_q[SumW-1:64]));
    endcase
    part = slice * $signed({1'b0, mix_coef_q});
    unique case (step_q[1:0])
      2'd0: part_sh = ProdW'(part);
      2'd1: part_sh = ProdW'(part) <<< 32;
      default: part_sh = ProdW'(part) <<< 64;
    endcase
  end

  // Arithmetic shift and saturation.
  logic signed [ProdW-1:0] shifted;
  logic                    sat;
  logic signed [DataW-1:0] res;
  always_comb begin
    shifted = acc_q >>> result_shift_q;
    sat     = !((&shifted[ProdW-1:DataW-1]) || !(|shifted[ProdW-1:DataW-1]));
    if (sat) begin
      res = shifted[ProdW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      res = shifted[DataW-1:0];
    end
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      emit_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output register loads a new result or empties once taken.
      if (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            emit_q  <= interior;
            state_q <= interior ? ST_RD_C : ST_WB;
          end
        end
        ST_RD_C: state_q <= ST_RD_E;
        ST_RD_E: state_q <= ST_RD_W;
        ST_RD_W: state_q <= ST_RD_N;
        ST_RD_N: state_q <= ST_WB;
        ST_WB: begin
          // Advance the raster position after the write-back.
          if (col_q == LastCol) begin
            col_q <= '0;
            row_q <= (row_q == LastRow) ? '0 : row_q + RW'(1);
          end else begin
            col_q <= col_q + CW'(1);
          end
          step_q  <= '0;
          state_q <= emit_q ? ST_TERM : ST_IDLE;
        end
        ST_TERM: begin
          if (step_q == 3'd4) begin
            step_q  <= '0;
            state_q <= ST_MIX;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_MIX: begin
          if (step_q == 3'd2) begin
            state_q <= ST_FIN;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ts_q       <= tracer_i;
      mc_q       <= mc_d;
      emit_row_q <= r_ext[PosW-1:0];
      emit_col_q <= c_ext[PosW-1:0];
    end
    if (state_q == ST_RD_E) begin
      tc_q <= trc_rdata_q;
      k_q  <= coef_rdata_q;
    end
    if (state_q == ST_RD_W) begin
      te_q <= trc_rdata_q;
    end
    if (state_q == ST_RD_N) begin
      tw_q <= trc_rdata_q;
    end
    if (state_q == ST_WB) begin
      tn_q <= trc_rdata_q;
    end
    if (state_q == ST_TERM) begin
      prod_q <= TermW'(term_full);
      if (step_q == 3'd0) begin
        sum_q <= '0;
      end else begin
        sum_q <= sum_q + SumW'(prod_q);
      end
    end
    if (state_q == ST_MIX) begin
      acc_q <= (step_q == 3'd0) ? part_sh : acc_q + part_sh;
    end
    if (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) begin
      out_row_q   <= emit_row_q;
      out_col_q   <= emit_col_q;
      tendency_q  <= res;
      saturated_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign tendency_o  = tendency_q;
  assign saturated_o = saturated_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  a_no_emit_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB && !emit_q) |=> (state_q == ST_IDLE))
    else $error("non-interior point entered the arithmetic");
  a_emit_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_col_q != '0 && out_row_q != '0))
    else $error("halo point emitted");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < ROW_LENGTH && 32'(row_q) < ROW_COUNT)
    else $error("raster position out of range");
`endif

endmodule

// File: verif/tracer_laplacian_mix_stencil_tb.sv
module tracer_laplacian_mix_stencil_tb;
  import tlms_pkg::*;

  localparam int unsigned RowLen   = 128;
  localparam int unsigned RowCnt   = 128;
  localparam int unsigned IdleWait = 40;
  localparam int unsigned DogLimit = 5000;

  typedef struct {
    logic signed [31:0] tracer;
    logic [31:0]        coef[4];
    logic [7:0]         depth_here;
    logic [7:0]         depth_nb[4];
  } grid_point_t;

  typedef struct {
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] tendency;
    logic               sat;
  } tendency_t;

  // Tracks the grid position, line buffers and registers, and keeps the
  // tendencies still to come in arrival order.
  class tendency_board;
    logic [31:0] tracer_line[2*RowLen];
    logic [31:0] kept_coef[RowLen][4];
    int unsigned row_pos, col_pos;
    logic [7:0]  level;
    logic [31:0] mix_coef;
    logic [5:0]  shift;
    logic [6:0]  first_col, last_col, first_row, last_row;
    tendency_t   pending[$];
    int unsigned mismatches;

    function new();
      row_pos = 0; col_pos = 0; level = 0; mix_coef = 0; shift = 32;
      first_col = 1; last_col = 126; first_row = 1; last_row = 126;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_LEVEL:        level     = val[7:0];
        CFG_MIX_COEF:     mix_coef  = val;
        CFG_RESULT_SHIFT: shift     = val[5:0];
        CFG_FIRST_COL:    first_col = val[6:0];
        CFG_LAST_COL:     last_col  = val[6:0];
        CFG_FIRST_ROW:    first_row = val[6:0];
        CFG_LAST_ROW:     last_row  = val[6:0];
        default: ;
      endcase
    endfunction

    // Note one accepted point; queue the tendency of the point above it.
    function void note_point(grid_point_t p);
      int unsigned cur_slot, prev_slot, r, c, i;
      logic [8:0]  kk;
      logic [31:0] kept[4];
      longint      tc, nb[4];
      logic signed [127:0] acc, dw, v;
      tendency_t   e;
      c = col_pos;
      cur_slot = (row_pos & 1) * RowLen;
      kk = {1'b0, level} + 9'd1;
      for (i = 0; i < 4; i++)
        kept[i] = (kk <= p.depth_nb[i] && kk <= p.depth_here) ? p.coef[i] : 32'd0;
      if (row_pos >= 1) begin
        r = row_pos - 1;
        prev_slot = (r & 1) * RowLen;
        if (r >= 1 && r + 1 < RowCnt && c >= 1 && c + 1 < RowLen &&
            r >= first_row && r <= last_row && c >= first_col && c <= last_col) begin
          tc    = longint'($signed(tracer_line[prev_slot + c]));
          nb[0] = longint'($signed(tracer_line[cur_slot + c]));
          nb[1] = longint'(p.tracer);
          nb[2] = longint'($signed(tracer_line[prev_slot + c + 1]));
          nb[3] = longint'($signed(tracer_line[prev_slot + c - 1]));
          acc = '0;
          for (i = 0; i < 4; i++) begin
            dw = nb[i] - tc;
            acc = acc + dw * $signed({96'd0, kept_coef[c][i]});
          end
          v = (acc * $signed({96'd0, mix_coef})) >>> shift;
          e.row = r[6:0];
          e.col = c[6:0];
          e.sat = 1'b1;
          if (v > 128'sd2147483647) e.tendency = 32'sh7FFFFFFF;
          else if (v < -128'sd2147483648) e.tendency = 32'sh80000000;
          else begin
            e.tendency = v[31:0];
            e.sat = 1'b0;
          end
          pending.push_back(e);
        end
      end
      tracer_line[cur_slot + c] = p.tracer;
      for (i = 0; i < 4; i++) kept_coef[c][i] = kept[i];
      col_pos++;
      if (col_pos >= RowLen) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= RowCnt) ? 0 : row_pos + 1;
      end
    endfunction

    // Compare one delivered tendency with the oldest one pending.
    function void check_result(tendency_t got);
      tendency_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: row %0d col %0d tendency %0d sat %0d",
                   got.row, got.col, got.tendency, got.sat);
        return;
      end
      want = pending.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.tendency !== want.tendency || got.sat !== want.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected r%0d c%0d %0d sat %0d, got r%0d c%0d %0d sat %0d",
                   want.row, want.col, want.tendency, want.sat,
                   got.row, got.col, got.tendency, got.sat);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataW-1:0] tracer_i = '0;
  logic [DataW-1:0] coef_prev_row_i = '0, coef_next_row_i = '0;
  logic [DataW-1:0] coef_next_col_i = '0, coef_prev_col_i = '0;
  logic [DepthW-1:0] depth_here_i = '0, depth_prev_row_i = '0, depth_next_row_i = '0;
  logic [DepthW-1:0] depth_next_col_i = '0, depth_prev_col_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [PosW-1:0] out_row_o, out_col_o;
  logic signed [DataW-1:0] tendency_o;
  logic saturated_o;

  tendency_board sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned points_sent = 0;
  logic timed_out = 1'b0;

  tracer_laplacian_mix_stencil #(.ROW_LENGTH(RowLen), .ROW_COUNT(RowCnt)) uut (.*);

  always #6 clk_i = ~clk_i;

  // Receiver: check delivered words, stall at random, and hold off once for a
  // long stretch so the block backs up into its input.
  always @(posedge clk_i) begin
    tendency_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (out_valid_o && !out_stall_i) begin
      got.row = out_row_o;
      got.col = out_col_o;
      got.tendency = tendency_o;
      got.sat = saturated_o;
      sb.check_result(got);
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (cycle_cnt == 1500) begin
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if ((cycle_cnt / 500) % 4 == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  // Watchdog on cycles with no accepted word on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= DogLimit && !timed_out) begin
      timed_out <= 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_depth(logic [7:0] lvl);
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd255;
      2: return lvl;
      3, 4: return lvl + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic grid_point_t make_point(logic [7:0] lvl);
    grid_point_t p;
    case ($urandom_range(0, 7))
      0: p.tracer = 32'sh80000000;
      1: p.tracer = 32'sh7FFFFFFF;
      2: p.tracer = '0;
      3: p.tracer = $urandom_range(0, 4095) - 2048;
      default: p.tracer = $urandom();
    endcase
    p.depth_here = pick_depth(lvl);
    for (int i = 0; i < 4; i++) begin
      p.coef[i] = pick_coef();
      p.depth_nb[i] = pick_depth(lvl);
    end
    return p;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Wait until every pending tendency has come, then let in-flight points drain.
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic send_points(int unsigned count, logic calm);
    grid_point_t p;
    int unsigned gap;
    for (int unsigned n = 0; n < count; n++) begin
      p = make_point(sb.level);
      in_valid_i       <= 1'b1;
      tracer_i         <= p.tracer;
      coef_prev_row_i  <= p.coef[0];
      coef_next_row_i  <= p.coef[1];
      coef_next_col_i  <= p.coef[2];
      coef_prev_col_i  <= p.coef[3];
      depth_here_i     <= p.depth_here;
      depth_prev_row_i <= p.depth_nb[0];
      depth_next_row_i <= p.depth_nb[1];
      depth_next_col_i <= p.depth_nb[2];
      depth_prev_col_i <= p.depth_nb[3];
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      sb.note_point(p);
      points_sent++;
      gap = (calm || (points_sent / 150) % 3 == 0) ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic set_all(logic [7:0] lvl, logic [31:0] mix, logic [5:0] sh,
                         logic [6:0] fc, logic [6:0] lc, logic [6:0] fr, logic [6:0] lr);
    write_reg(CFG_LEVEL, 32'(lvl));
    write_reg(CFG_MIX_COEF, mix);
    write_reg(CFG_RESULT_SHIFT, 32'(sh));
    write_reg(CFG_FIRST_COL, 32'(fc));
    write_reg(CFG_LAST_COL, 32'(lc));
    write_reg(CFG_FIRST_ROW, 32'(fr));
    write_reg(CFG_LAST_ROW, 32'(lr));
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus: reset defaults first, then extreme and random settings, and a
  // narrow band of rows.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: zero scale, so every interior tendency is zero.
    send_points(200, 1'b0);
    wait_idle();
    // Full scale, no shift: mostly saturated tendencies.
    set_all(8'd0, 32'hFFFFFFFF, 6'd0, 7'd1, 7'd126, 7'd1, 7'd126);
    send_points(200, 1'b1);
    wait_idle();
    // Level 255 masks every coefficient; inverted column bounds emit nothing.
    set_all(8'd255, $urandom(), 6'd63, 7'd126, 7'd1, 7'd1, 7'd126);
    send_points(100, 1'b0);
    wait_idle();
    // Narrow band of columns at the far edge of the grid, including the halo edge.
    set_all(8'd254, $urandom(), 6'd32, 7'd120, 7'd126, 7'd1, 7'd126);
    send_points(150, 1'b0);
    wait_idle();
    // Only a single row emits.
    set_all(8'($urandom_range(0, 20)), $urandom(), 6'($urandom_range(16, 40)),
            7'd1, 7'd126, 7'd5, 7'd5);
    send_points(150, 1'b0);
    wait_idle();
    // Random settings.
    for (int ph = 0; ph < 3; ph++) begin
      set_all(8'($urandom_range(0, 30)), $urandom(), 6'($urandom_range(0, 63)),
              7'($urandom_range(1, 60)), 7'($urandom_range(60, 126)),
              7'($urandom_range(1, 2)), 7'($urandom_range(100, 126)));
      send_points(70, 1'b0);
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
